// ===== hw/rtl/bda_pkg.sv =====
// shared constants and state codes for the binary to decimal ascii converter
package bda_pkg;

  // fixed field widths
  localparam int VALUE_BITS  = 32;
  localparam int MIN_W       = 5;
  localparam int CHAR_W      = 6;
  localparam int DIGIT_W     = 4;

  // ten bcd digits cover every 32-bit value
  localparam int BCD_NIBBLES = 10;
  localparam int NIB_IDX_W   = $clog2(BCD_NIBBLES);
  localparam int STEP_W      = $clog2(VALUE_BITS);

  // default cap on the output run length
  localparam int MAX_DIGITS_DEF = 20;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

  // controller states, one-hot
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CONV = 4'b0010,
    S_SIZE = 4'b0100,
    S_EMIT = 4'b1000
  } bda_state_t;

endpackage

// ===== hw/rtl/bda_in_if.sv =====
// input channel: value and minimum digit count
interface bda_in_if
  import bda_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;
  logic [MIN_W-1:0]      min_chars;

  modport source (output valid, value, min_chars, input ready);
  modport sink   (input valid, value, min_chars, output ready);
endinterface

// ===== hw/rtl/bda_out_if.sv =====
// output channel: one ascii digit per word plus last flag
interface bda_out_if
  import bda_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] digit_char;
  logic              last;

  modport source (output valid, digit_char, last, input ready);
  modport sink   (input valid, digit_char, last, output ready);
endinterface

// ===== hw/rtl/bda_cell.sv =====
// one bcd digit cell of the shift and add-3 chain
module bda_cell
  import bda_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               clear,
  input  logic               shift_en,
  input  logic               carry_in,
  output logic               carry_out,
  output logic [DIGIT_W-1:0] digit
);

  logic [DIGIT_W-1:0] adj;

  // add 3 when the digit would overflow past 9 after doubling
  always_comb begin
    adj       = (digit >= 4'd5) ? digit + 4'd3 : digit;
    carry_out = adj[DIGIT_W-1];
  end

  // digit register: shift left taking the neighbor's carry
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      digit <= '0;
    end else if (shift_en) begin
      digit <= {adj[DIGIT_W-2:0], carry_in};
    end
  end

endmodule

// ===== hw/rtl/binary_to_decimal_ascii_top.sv =====
// binary to decimal ascii converter: digit cell chain, sizing and emit control
//
//   channel  | dir | payload                      | handshake
//   in_ch    | in  | value[31:0], min_chars[4:0]  | valid / ready
//   out_ch   | out | digit_char[5:0], last        | valid / ready
//
// a word is accepted in idle, shifted msb first through the ten digit cells one bit
// per conversion step, sized, then emitted one character per cycle while the
// output is not stalled, 1 to MAX_DIGITS characters per run.
// synchronous active-high reset clears the controller and the output valid.
// the output register holds a stalled character; the next input word is
// taken while the final character of the previous run still waits.
module binary_to_decimal_ascii_top
  import bda_pkg::*;
#(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  bda_in_if.sink     in_ch,
  bda_out_if.source  out_ch
);

  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int CMP_W = (CNT_W > MIN_W) ? CNT_W : MIN_W;

  bda_state_t            state;
  logic [VALUE_BITS-1:0] val_sr;
  logic [MIN_W-1:0]      min_reg;
  logic [STEP_W-1:0]     step;
  logic [CNT_W-1:0]      pos;
  logic                  out_valid;
  logic [CHAR_W-1:0]     out_char;
  logic                  out_last;

  logic                  accept;
  logic                  shift_en;
  logic                  load;
  logic [DIGIT_W-1:0]    digits [BCD_NIBBLES];
  logic                  carry  [BCD_NIBBLES];
  logic [DIGIT_W-1:0]    sig;
  logic [CMP_W-1:0]      min_sat;
  logic [CMP_W-1:0]      count;
  logic [DIGIT_W-1:0]    cur_digit;

  assign accept   = in_ch.valid && in_ch.ready;
  assign shift_en = (state == S_CONV);
  assign load     = (state == S_EMIT) && (!out_valid || out_ch.ready);

  assign in_ch.ready       = (state == S_IDLE);
  assign out_ch.valid      = out_valid;
  assign out_ch.digit_char = out_char;
  assign out_ch.last       = out_last;

  // row of digit cells, value bits enter at the low cell msb first
  for (genvar i = 0; i < BCD_NIBBLES; i++) begin : g_cell
    bda_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .clear     (accept),
      .shift_en  (shift_en),
      .carry_in  ((i == 0) ? val_sr[VALUE_BITS-1] : carry[(i == 0) ? 0 : i-1]),
      .carry_out (carry[i]),
      .digit     (digits[i])
    );
  end

  // significant digit count: highest nonzero digit, at least one
  always_comb begin
    sig = 4'd1;
    for (int n = 1; n < BCD_NIBBLES; n++) begin
      if (digits[n] != '0) begin
        sig = DIGIT_W'(n + 1);
      end
    end
  end

  // run length: max of significant digits and capped minimum
  always_comb begin
    min_sat = (CMP_W'(min_reg) > CMP_W'(MAX_DIGITS)) ? CMP_W'(MAX_DIGITS) : CMP_W'(min_reg);
    count   = (CMP_W'(sig) > min_sat) ? CMP_W'(sig) : min_sat;
  end

  // digit at the current position, padding zero above the chain
  always_comb begin
    if (pos < CNT_W'(BCD_NIBBLES)) begin
      cur_digit = digits[pos[NIB_IDX_W-1:0]];
    end else begin
      cur_digit = '0;
    end
  end

  // controller
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_CONV;
            step  <= '0;
          end
        end
        S_CONV: begin
          step <= step + 1'b1;
          if (step == STEP_W'(VALUE_BITS - 1)) begin
            state <= S_SIZE;
          end
        end
        S_SIZE: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (load && pos == '0) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // input capture and value shift register
  always_ff @(posedge clk) begin
    if (accept) begin
      val_sr  <= in_ch.value;
      min_reg <= in_ch.min_chars;
    end else if (shift_en) begin
      val_sr  <= {val_sr[VALUE_BITS-2:0], 1'b0};
    end
  end

  // character position counter
  always_ff @(posedge clk) begin
    if (state == S_SIZE) begin
      pos <= CNT_W'(count - 1'b1);
    end else if (load) begin
      pos <= pos - 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_char <= ASCII_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, cur_digit};
      out_last <= (pos == '0);
    end
  end

endmodule

// ===== sim/binary_to_decimal_ascii_top_test.sv =====
// testbench for the binary to decimal ascii converter: random and edge values, scoreboard check
`timescale 1ns / 1ps

module binary_to_decimal_ascii_top_test;
  import bda_pkg::*;

  localparam int RUN_CAP      = MAX_DIGITS_DEF;
  localparam int IDLE_LIMIT   = 3000;
  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_WORDS = 390;
  localparam int DRAIN_CYCLES = 34 + RUN_CAP + 10;

  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic              last;
  } char_word_t;

  // expected character runs, oldest first
  class digit_scoreboard;
    char_word_t pending_chars[$];
    int         error_count = 0;

    // predict the character run for one accepted input word
    function void note_word(logic [VALUE_BITS-1:0] value, logic [MIN_W-1:0] min_chars);
      logic [DIGIT_W-1:0]    dig [BCD_NIBBLES];
      logic [VALUE_BITS-1:0] rest;
      int                    sig;
      int                    minimum;
      int                    count;
      char_word_t            w;
      rest = value;
      for (int i = 0; i < BCD_NIBBLES; i++) begin
        dig[i] = DIGIT_W'(rest % 10);
        rest   = rest / 10;
      end
      sig = 1;
      for (int n = BCD_NIBBLES - 1; n > 0; n--) begin
        if (dig[n] != 0) begin
          sig = n + 1;
          break;
        end
      end
      minimum = (min_chars > RUN_CAP) ? RUN_CAP : int'(min_chars);
      count   = (sig > minimum) ? sig : minimum;
      // most significant first, padding zeros above the ten bcd digits
      for (int pos = count - 1; pos >= 0; pos--) begin
        w.digit_char = ASCII_ZERO + ((pos < BCD_NIBBLES) ? dig[pos] : 4'd0);
        w.last       = (pos == 0);
        pending_chars.push_back(w);
      end
    endfunction

    // compare one output word with the oldest expectation
    function void check_char(logic [CHAR_W-1:0] digit_char, logic last);
      char_word_t w;
      if (pending_chars.size() == 0) begin
        $error("unexpected output word: digit_char=%0d last=%0b", digit_char, last);
        error_count++;
        return;
      end
      w = pending_chars.pop_front();
      if (digit_char !== w.digit_char) begin
        $error("digit_char mismatch: expected %0d, actual %0d", w.digit_char, digit_char);
        error_count++;
      end
      if (last !== w.last) begin
        $error("last mismatch: expected %0b, actual %0b", w.last, last);
        error_count++;
      end
    endfunction

    function int pending_count();
      return pending_chars.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  bda_in_if  in_ch ();
  bda_out_if out_ch ();

  binary_to_decimal_ascii_top DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  digit_scoreboard sb = new();
  int words_taken = 0;
  int idle_cycles = 0;
  int burst_left;

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // monitor both channels
  always @(posedge clk) begin
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        sb.note_word(in_ch.value, in_ch.min_chars);
        words_taken++;
      end
      if (out_ch.valid && out_ch.ready) begin
        sb.check_char(out_ch.digit_char, out_ch.last);
      end
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("binary_to_decimal_ascii_top_test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver stall pattern with one long hold-off
  initial begin
    int hold_left;
    int run_left;
    int mode;
    bit hold_done;
    hold_left = 0;
    run_left  = 0;
    mode      = 0;
    hold_done = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && words_taken >= 60) begin
        hold_done = 1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        if (run_left == 0) begin
          mode     = $urandom_range(0, 3);
          run_left = $urandom_range(5, 80);
        end
        run_left--;
        case (mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= ($urandom_range(0, 1) == 1);
          2:       out_ch.ready <= ($urandom_range(0, 7) != 0);
          default: out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // offer one word and hold it until accepted
  task automatic send_word(logic [VALUE_BITS-1:0] v, logic [MIN_W-1:0] m);
    in_ch.valid     <= 1'b1;
    in_ch.value     <= v;
    in_ch.min_chars <= m;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // send in bursts with random gaps between them
  task automatic offer_word(logic [VALUE_BITS-1:0] v, logic [MIN_W-1:0] m);
    int gap;
    send_word(v, m);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 30) : $urandom_range(1, 8);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
      if (gap > 0) begin
        in_ch.valid     <= 1'b0;
        in_ch.value     <= $urandom;
        in_ch.min_chars <= MIN_W'($urandom_range(0, 31));
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // random value: full range, short numbers, values near the maximum, powers of ten and their neighbors
  function automatic logic [VALUE_BITS-1:0] rand_value();
    logic [VALUE_BITS-1:0] p;
    int k;
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom >> $urandom_range(0, 31);
      2: begin
        p = 1;
        k = $urandom_range(0, 9);
        repeat (k) p = p * 10;
        return p + $urandom_range(0, 2) - 1;
      end
      3: return $urandom_range(0, 20);
      4: return 32'hFFFF_FFFF - $urandom_range(0, 100);
      default: return $urandom;
    endcase
  endfunction

  // stimulus
  initial begin
    logic [MIN_W-1:0] m;
    rst             <= 1'b1;
    in_ch.valid     <= 1'b0;
    in_ch.value     <= '0;
    in_ch.min_chars <= '0;
    burst_left = $urandom_range(1, 8);
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // zero value, with and without padding and with a saturated minimum
    offer_word(32'd0, 5'd0);
    offer_word(32'd0, 5'd1);
    offer_word(32'd0, 5'd7);
    offer_word(32'd0, 5'd20);
    offer_word(32'd0, 5'd31);
    // largest value, minimum below, equal to and above its ten digits
    offer_word(32'hFFFF_FFFF, 5'd0);
    offer_word(32'hFFFF_FFFF, 5'd10);
    offer_word(32'hFFFF_FFFF, 5'd20);
    offer_word(32'hFFFF_FFFF, 5'd21);
    // digit count boundaries
    offer_word(32'd9, 5'd0);
    offer_word(32'd10, 5'd1);
    offer_word(32'd99, 5'd2);
    offer_word(32'd100, 5'd3);
    offer_word(32'd999_999_999, 5'd0);
    offer_word(32'd1_000_000_000, 5'd0);
    // padding with a minimum above the digit count
    offer_word(32'd1, 5'd10);
    offer_word(32'd12345, 5'd6);
    offer_word(32'd1_234_567_890, 5'd15);
    // alternating bit patterns and every minimum bit
    offer_word(32'h8000_0000, 5'd16);
    offer_word(32'h5555_5555, 5'd31);
    offer_word(32'hAAAA_AAAA, 5'd8);
    offer_word(32'h7FFF_FFFF, 5'd4);

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: m = MIN_W'($urandom_range(0, 12));
        5, 6, 7:       m = MIN_W'($urandom_range(0, 31));
        default:       m = MIN_W'($urandom_range(18, 31));
      endcase
      offer_word(rand_value(), m);
    end
    in_ch.valid <= 1'b0;

    // let the monitor note the last word, drain, then watch for stray words
    @(posedge clk);
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.error_count == 0 && sb.pending_count() == 0) begin
      $display("binary_to_decimal_ascii_top_test passed");
    end else begin
      $display("binary_to_decimal_ascii_top_test failed");
    end
    $finish;
  end

endmodule

// ===== binary_to_decimal_ascii_top.f =====
hw/rtl/bda_pkg.sv
hw/rtl/bda_in_if.sv
hw/rtl/bda_out_if.sv
hw/rtl/bda_cell.sv
hw/rtl/binary_to_decimal_ascii_top.sv
sim/binary_to_decimal_ascii_top_test.sv
